>>> hw/rtl/rdq_pkg.sv
// ============================================================================
// rdq_pkg
// Types, codes and defaults shared by the ring deque controller, datapath
// and top level.
// ============================================================================
package rdq_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT = 32;
    localparam int ADDR_W                = 32;
    localparam int WORD_W                = 32;
    localparam int OCC_W                 = 5;
    localparam int RESERVE_W             = 4;
    localparam logic [RESERVE_W-1:0] BACK_RESERVE_RESET = 4'd1;

    typedef enum logic [1:0] {
        CMD_PUSH_TAIL = 2'd0,
        CMD_PUSH_HEAD = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_FLUSH     = 2'd3
    } t_command;

    typedef struct packed {
        t_command            command;
        logic [ADDR_W-1:0]   msg_address;
        logic [WORD_W-1:0]   msg_payload;
    } t_cmd_item;

    typedef struct packed {
        logic                accepted;
        logic [ADDR_W-1:0]   out_address;
        logic [WORD_W-1:0]   out_payload;
        logic [OCC_W-1:0]    occupancy;
    } t_result_item;

    // Operation the controller asks of the datapath in the execute cycle.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_PUSH_HEAD = 3'd2,
        OP_POP       = 3'd3,
        OP_FLUSH     = 3'd4,
        OP_REFUSE    = 3'd5
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_command cmd;
        logic     tail_ok;
        logic     head_ok;
        logic     pop_ok;
    } t_dp_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

>>> hw/rtl/rdq_ctrl.sv
// ============================================================================
// rdq_ctrl
// Command sequencer: takes a command in, then decides in the execute cycle
// which queue operation the datapath carries out.
// ============================================================================
module rdq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rdq_pkg::t_dp_status i_status,
    output logic                o_busy,
    output rdq_pkg::t_dp_cmd    o_dp_cmd
);

    rdq_pkg::t_state r_state;
    rdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_busy           = 1'b0;
        o_dp_cmd.capture = 1'b0;
        o_dp_cmd.op      = rdq_pkg::OP_NONE;
        unique case (r_state)
            rdq_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state          = rdq_pkg::ST_EXEC;
                end
            end
            rdq_pkg::ST_EXEC: begin
                o_busy  = 1'b1;
                n_state = rdq_pkg::ST_IDLE;
                unique case (i_status.cmd)
                    rdq_pkg::CMD_PUSH_TAIL: begin
                        o_dp_cmd.op = i_status.tail_ok ? rdq_pkg::OP_PUSH_TAIL
                                                       : rdq_pkg::OP_REFUSE;
                    end
                    rdq_pkg::CMD_PUSH_HEAD: begin
                        o_dp_cmd.op = i_status.head_ok ? rdq_pkg::OP_PUSH_HEAD
                                                       : rdq_pkg::OP_REFUSE;
                    end
                    rdq_pkg::CMD_POP_HEAD: begin
                        o_dp_cmd.op = i_status.pop_ok ? rdq_pkg::OP_POP
                                                      : rdq_pkg::OP_REFUSE;
                    end
                    rdq_pkg::CMD_FLUSH: begin
                        o_dp_cmd.op = rdq_pkg::OP_FLUSH;
                    end
                endcase
            end
        endcase
    end

endmodule

>>> hw/rtl/rdq_datapath.sv
// ============================================================================
// rdq_datapath
// Slot memory, head and tail pointers, entry count and the result register.
// ============================================================================
module rdq_datapath #(
    parameter int DEPTH         = rdq_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = rdq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rdq_pkg::t_cmd_item              i_item,
    input  logic [rdq_pkg::RESERVE_W-1:0]   i_back_reserve,
    input  rdq_pkg::t_dp_cmd                i_dp_cmd,
    output rdq_pkg::t_dp_status             o_status,
    output logic                            o_done,
    output rdq_pkg::t_result_item           o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > rdq_pkg::RESERVE_W) ? CW : rdq_pkg::RESERVE_W) + 1;
    localparam int EW = rdq_pkg::ADDR_W + PAYLOAD_WIDTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic [EW-1:0]        r_mem [DEPTH];
    logic [EW-1:0]        r_rd_data;
    rdq_pkg::t_cmd_item   r_item;
    logic [AW-1:0]        r_head;
    logic [AW-1:0]        r_tail;
    logic [CW-1:0]        r_count;
    logic                 r_done;
    rdq_pkg::t_result_item r_result;

    logic [AW-1:0]        n_head;
    logic [AW-1:0]        n_tail;
    logic [CW-1:0]        n_count;
    logic [AW-1:0]        head_inc;
    logic [AW-1:0]        head_dec;
    logic [AW-1:0]        tail_inc;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    rdq_pkg::t_result_item n_result;

    assign head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
    assign tail_inc = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;

    assign o_status.cmd     = r_item.command;
    assign o_status.tail_ok = (SW'(r_count) + SW'(i_back_reserve)) < SW'(DEPTH);
    assign o_status.head_ok = (r_count != CW'(DEPTH));
    assign o_status.pop_ok  = (r_count != '0);

    assign wr_data = {r_item.msg_address, r_item.msg_payload[PAYLOAD_WIDTH-1:0]};

    always_comb begin
        n_head               = r_head;
        n_tail               = r_tail;
        n_count              = r_count;
        wr_en                = 1'b0;
        wr_addr              = r_tail;
        n_result.accepted    = 1'b1;
        n_result.out_address = '0;
        n_result.out_payload = '0;
        unique case (i_dp_cmd.op)
            rdq_pkg::OP_NONE: begin
                n_result.accepted = 1'b0;
            end
            rdq_pkg::OP_PUSH_TAIL: begin
                wr_en   = 1'b1;
                wr_addr = r_tail;
                n_tail  = tail_inc;
                n_count = r_count + 1'b1;
            end
            rdq_pkg::OP_PUSH_HEAD: begin
                wr_en   = 1'b1;
                wr_addr = head_dec;
                n_head  = head_dec;
                n_count = r_count + 1'b1;
            end
            rdq_pkg::OP_POP: begin
                // The slot was read at the head in the capture cycle.
                n_result.out_address = r_rd_data[PAYLOAD_WIDTH +: rdq_pkg::ADDR_W];
                n_result.out_payload = rdq_pkg::WORD_W'(r_rd_data[PAYLOAD_WIDTH-1:0]);
                n_head               = head_inc;
                n_count              = r_count - 1'b1;
            end
            rdq_pkg::OP_FLUSH: begin
                n_head  = r_tail;
                n_count = '0;
            end
            rdq_pkg::OP_REFUSE: begin
                n_result.accepted = 1'b0;
            end
            default: begin
                n_result.accepted = 1'b0;
            end
        endcase
        n_result.occupancy = rdq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_dp_cmd.op != rdq_pkg::OP_NONE) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= (i_dp_cmd.op != rdq_pkg::OP_NONE);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail apart with queue empty or full");

    a_refuse_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.op == rdq_pkg::OP_REFUSE) |=> (r_done && !r_result.accepted
            && $stable(r_count) && $stable(r_head) && $stable(r_tail)))
        else $error("refused command changed the queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.op == rdq_pkg::OP_POP) |=>
            (r_count == $past(r_count) - 1'b1) && r_result.accepted)
        else $error("pop did not take one entry");

endmodule

>>> hw/rtl/ring_deque_with_reserve_unit.sv
// ============================================================================
// ring_deque_with_reserve_unit
// Circular message queue with tail push, head push, head pop and flush,
// and a configurable reserve of slots kept for head pushes.
// ============================================================================
// A command is taken at a rising edge with start high and busy low. Busy
// is high for the one execute cycle after the transfer, because the slot at
// the head is read from the registered slot memory during the transfer cycle
// and used in the execute cycle. The result is shown for exactly one cycle
// with o_done high, in the cycle after the execute cycle, and the next
// command may be transferred in that same cycle. Results cannot be held
// off; a receiver must take each one as it is shown. The slot memory needs
// no clearing after reset. The user must write the reserve register through
// the APB port at word address 0 (byte addresses 0 to 3) only while no
// command is in flight; the block itself does not enforce this.
module ring_deque_with_reserve_unit #(
    parameter int DEPTH         = rdq_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = rdq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rdq_pkg::t_cmd_item    i_cmd,
    output logic                  o_done,
    output rdq_pkg::t_result_item o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic REG_BACK_RESERVE = 1'b0;

    logic [rdq_pkg::RESERVE_W-1:0] r_back_reserve;
    logic                          reg_hit;
    rdq_pkg::t_dp_cmd              dp_cmd;
    rdq_pkg::t_dp_status           dp_status;

    // Register index is the word address; byte offsets within it are ignored.
    assign reg_hit = (paddr[2] == REG_BACK_RESERVE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? 32'(r_back_reserve) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_reserve <= rdq_pkg::BACK_RESERVE_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_back_reserve <= pwdata[rdq_pkg::RESERVE_W-1:0];
        end
    end

    rdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_dp_cmd (dp_cmd)
    );

    rdq_datapath #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_cmd),
        .i_back_reserve (r_back_reserve),
        .i_dp_cmd       (dp_cmd),
        .o_status       (dp_status),
        .o_done         (o_done),
        .o_result       (o_result)
    );

endmodule

>>> bench/ring_deque_with_reserve_unit_test.sv
// ============================================================================
// ring_deque_with_reserve_unit_test
// Self-checking bench for the ring deque. Commands are driven through the
// start/busy handshake. Results are predicted by a scoreboard that keeps its
// own copy of the slots, pointers, count and reserve. The reserve register is
// exercised over APB, at its extremes and at random values, between phases
// of fill-heavy, drain-heavy and mixed random traffic.
// ============================================================================
module ring_deque_with_reserve_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH        = rdq_pkg::DEPTH_DEFAULT;
    localparam int         STALL_LIMIT  = 200;
    localparam int         SEGMENTS     = 16;
    localparam int         SEGMENT_LEN  = 100;
    localparam int         DRAIN_CYCLES = 4;
    localparam logic [2:0] RESERVE_ADDR = 3'd0;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct packed {
        logic [rdq_pkg::ADDR_W-1:0] address;
        logic [rdq_pkg::WORD_W-1:0] payload;
    } t_slot;

    class deque_scoreboard;
        t_slot                         slots[DEPTH];
        int unsigned                   head_idx;
        int unsigned                   tail_idx;
        int unsigned                   count;
        logic [rdq_pkg::RESERVE_W-1:0] reserve;
        rdq_pkg::t_result_item         expected_q[$];
        int                            errors;

        function new();
            head_idx = 0;
            tail_idx = 0;
            count    = 0;
            reserve  = rdq_pkg::BACK_RESERVE_RESET;
            errors   = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void set_reserve(logic [31:0] value);
            reserve = value[rdq_pkg::RESERVE_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the result of one transferred command and moves the state on.
        function void note_command(rdq_pkg::t_cmd_item c);
            rdq_pkg::t_result_item r;
            r = '0;
            case (c.command)
                rdq_pkg::CMD_PUSH_TAIL: begin
                    if (count + reserve < DEPTH) begin
                        slots[tail_idx] = {c.msg_address, c.msg_payload};
                        tail_idx = (tail_idx + 1 >= DEPTH) ? 0 : tail_idx + 1;
                        count++;
                        r.accepted = 1'b1;
                    end
                end
                rdq_pkg::CMD_PUSH_HEAD: begin
                    if (count < DEPTH) begin
                        head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                        slots[head_idx] = {c.msg_address, c.msg_payload};
                        count++;
                        r.accepted = 1'b1;
                    end
                end
                rdq_pkg::CMD_POP_HEAD: begin
                    if (count > 0) begin
                        r.out_address = slots[head_idx].address;
                        r.out_payload = slots[head_idx].payload;
                        head_idx = (head_idx + 1 >= DEPTH) ? 0 : head_idx + 1;
                        count--;
                        r.accepted = 1'b1;
                    end
                end
                default: begin
                    head_idx   = tail_idx;
                    count      = 0;
                    r.accepted = 1'b1;
                end
            endcase
            r.occupancy = rdq_pkg::OCC_W'(count);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(rdq_pkg::t_result_item got);
            rdq_pkg::t_result_item want;
            if (expected_q.size() == 0) begin
                report("result with no command outstanding");
            end else begin
                want = expected_q.pop_front();
                if (got.accepted !== want.accepted)
                    report($sformatf("accepted %b, expected %b",
                                     got.accepted, want.accepted));
                if (got.out_address !== want.out_address)
                    report($sformatf("out_address %h, expected %h",
                                     got.out_address, want.out_address));
                if (got.out_payload !== want.out_payload)
                    report($sformatf("out_payload %h, expected %h",
                                     got.out_payload, want.out_payload));
                if (got.occupancy !== want.occupancy)
                    report($sformatf("occupancy %0d, expected %0d",
                                     got.occupancy, want.occupancy));
            end
        endtask
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    rdq_pkg::t_cmd_item    i_cmd   = '0;
    logic                  o_done;
    rdq_pkg::t_result_item o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [2:0]            paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    deque_scoreboard board = new();
    int              stall_cycles = 0;

    ring_deque_with_reserve_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Everything is sampled at the rising edge, before the edge's own updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_command(i_cmd);
            if (o_done) board.check_result(o_result);
            if (psel && penable && pwrite && pready) board.set_reserve(pwdata);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL ring_deque_with_reserve_unit");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return 32'h0000_0000;
        if (sel == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic rdq_pkg::t_cmd_item make_cmd(t_mix mix);
        rdq_pkg::t_cmd_item c;
        int unsigned        roll;
        int unsigned        tail_w;
        int unsigned        head_w;
        int unsigned        pop_w;
        case (mix)
            MIX_FILL:  begin tail_w = 45; head_w = 25; pop_w = 27; end
            MIX_DRAIN: begin tail_w = 20; head_w = 15; pop_w = 62; end
            default:   begin tail_w = 35; head_w = 20; pop_w = 40; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < tail_w)                       c.command = rdq_pkg::CMD_PUSH_TAIL;
        else if (roll < tail_w + head_w)         c.command = rdq_pkg::CMD_PUSH_HEAD;
        else if (roll < tail_w + head_w + pop_w) c.command = rdq_pkg::CMD_POP_HEAD;
        else                                     c.command = rdq_pkg::CMD_FLUSH;
        c.msg_address = pick_word();
        c.msg_payload = pick_word();
        return c;
    endfunction

    function automatic rdq_pkg::t_cmd_item cmd_of(rdq_pkg::t_command op,
                                                  logic [31:0] addr,
                                                  logic [31:0] data);
        rdq_pkg::t_cmd_item c;
        c.command     = op;
        c.msg_address = addr;
        c.msg_payload = data;
        return c;
    endfunction

    // Holds start high until the command is transferred.
    task automatic send_cmd(rdq_pkg::t_cmd_item c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // Lowers start for a while; the command bus carries junk meanwhile.
    task automatic pause(int cycles);
        start <= 1'b0;
        i_cmd <= {2'($urandom()), $urandom(), $urandom()};
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RESERVE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_reserve(logic [rdq_pkg::RESERVE_W-1:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {$urandom_range(0, 1) ? 28'($urandom()) : 28'h0, value}, rd);
        apb_access(1'b0, '0, rd);
        if (rd !== 32'(board.reserve))
            board.report($sformatf("reserve reads %h, expected %h", rd, board.reserve));
    endtask

    function automatic logic [rdq_pkg::RESERVE_W-1:0] reserve_for(int seg);
        case (seg)
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'd1;
            3:       return 4'd14;
            default: return rdq_pkg::RESERVE_W'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        logic [31:0] rd;
        t_mix        mix;
        bit          gaps_on;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reserve must come out of reset at its default.
        apb_access(1'b0, '0, rd);
        if (rd !== 32'(rdq_pkg::BACK_RESERVE_RESET))
            board.report($sformatf("reserve after reset %h", rd));

        // Pop and flush on an empty queue, then a head push that wraps the
        // head pointer back from slot zero.
        send_cmd(cmd_of(rdq_pkg::CMD_POP_HEAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(cmd_of(rdq_pkg::CMD_FLUSH, 32'h0, 32'h0));
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_HEAD, 32'hA5A5_5A5A, 32'h0123_4567));
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_TAIL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_TAIL, 32'h0, 32'h0));
        repeat (4) send_cmd(cmd_of(rdq_pkg::CMD_POP_HEAD, 32'h0, 32'h0));

        // Fill against the reserve, then top up at the head until full.
        for (int i = 0; i < DEPTH; i++)
            send_cmd(cmd_of(rdq_pkg::CMD_PUSH_TAIL, pick_word(), pick_word()));
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_HEAD, 32'h5A5A_A5A5, 32'hFEDC_BA98));
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_HEAD, 32'h1111_1111, 32'h2222_2222));
        send_cmd(cmd_of(rdq_pkg::CMD_POP_HEAD, 32'h0, 32'h0));
        send_cmd(cmd_of(rdq_pkg::CMD_FLUSH, 32'h0, 32'h0));
        send_cmd(cmd_of(rdq_pkg::CMD_POP_HEAD, 32'h0, 32'h0));
        wait_drained();

        // With the largest reserve only a single tail push gets in.
        set_reserve(4'd15);
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_TAIL, 32'hCAFE_0001, 32'h0000_0001));
        send_cmd(cmd_of(rdq_pkg::CMD_PUSH_TAIL, 32'hCAFE_0002, 32'h0000_0002));
        send_cmd(cmd_of(rdq_pkg::CMD_FLUSH, 32'h0, 32'h0));

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            set_reserve(reserve_for(seg));
            mix     = t_mix'($urandom_range(0, 2));
            gaps_on = (seg != 3) && (seg != 10);
            for (int k = 0; k < SEGMENT_LEN; k++) begin
                if (gaps_on && $urandom_range(0, 99) < 20) pause($urandom_range(1, 4));
                send_cmd(make_cmd(mix));
            end
        end

        wait_drained();
        if (board.errors == 0) begin
            $display("PASS ring_deque_with_reserve_unit");
        end else begin
            $display("FAIL ring_deque_with_reserve_unit");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_ctrl.sv
hw/rtl/rdq_datapath.sv
hw/rtl/ring_deque_with_reserve_unit.sv
bench/ring_deque_with_reserve_unit_test.sv
